// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/iirs_pkg.sv =====
package iirs_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int POS_W  = 10;
    localparam int DIM_W  = 11;
    localparam int PIX_W  = 8;
    localparam int ROWS_W = 18;
    localparam int SUM_W  = 28;
    localparam int CFG_AW = 3;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CFG_AW-1:0] {
        REG_FRAME_WIDTH = 3'd0,
        REG_ROI_X_MIN   = 3'd1,
        REG_ROI_X_MAX   = 3'd2,
        REG_ROI_Y_MIN   = 3'd3,
        REG_ROI_Y_MAX   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [POS_W-1:0] roi_x_min;
        logic [DIM_W-1:0] roi_x_max;
        logic [POS_W-1:0] roi_y_min;
        logic [DIM_W-1:0] roi_y_max;
    } cfg_t;

    typedef struct packed {
        logic              res;
        logic              above_en;
        logic              done;
        logic [POS_W-1:0]  rx;
        logic [POS_W-1:0]  ry;
        logic [ROWS_W-1:0] rs;
    } item_t;

    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] addr;
        logic [SUM_W-1:0] data;
    } ram_wr_t;

    function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] iw);
        logic [DIM_W-1:0] w;
        if (iw == '0) begin
            w = DIM_W'(1);
        end else if (iw > DIM_W'(MAX_WIDTH)) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = iw;
        end
        return w;
    endfunction

    function automatic logic [DIM_W-1:0] last_col(input cfg_t cfg);
        logic [DIM_W-1:0] w;
        w = eff_width(cfg.frame_width);
        return (cfg.roi_x_max < w) ? cfg.roi_x_max : w;
    endfunction

    function automatic logic [DIM_W-1:0] last_row(input cfg_t cfg);
        return (cfg.roi_y_max < DIM_W'(MAX_HEIGHT)) ? cfg.roi_y_max : DIM_W'(MAX_HEIGHT);
    endfunction

endpackage

// ===== rtl/integral_image_roi_stream_unit.sv =====
// An accepted pixel is held in stage s1; a region result then goes to the output register.
// Throughput: one pixel per cycle; input stalls only while a result waits with m_tready low.
// Reset: aresetn is synchronous and active low; it clears position, row sum,
// pipeline valid flags and restores the register reset values.
// The line buffer is not cleared and holds its contents until rewritten.
`include "assert_macros.svh"

module integral_image_roi_stream_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [iirs_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [iirs_pkg::DIM_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pixel [7:0]
    input  logic [iirs_pkg::S_TDATA_W-1:0] s_tdata,
    // frame_start [0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // area_sum [27:0], roi_col [37:28], roi_row [47:38]
    output logic [iirs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import iirs_pkg::*;

    cfg_t             cfg_reg;
    item_t            item;
    ram_wr_t          ram_wr;
    logic             accept;
    logic [SUM_W-1:0] rdata;
    logic [POS_W-1:0] done_col, done_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width <= DIM_W'(MAX_WIDTH);
            cfg_reg.roi_x_min   <= '0;
            cfg_reg.roi_x_max   <= DIM_W'(MAX_WIDTH);
            cfg_reg.roi_y_min   <= '0;
            cfg_reg.roi_y_max   <= DIM_W'(MAX_HEIGHT);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_WIDTH: cfg_reg.frame_width <= cfg_wdata;
                REG_ROI_X_MIN:   cfg_reg.roi_x_min   <= cfg_wdata[POS_W-1:0];
                REG_ROI_X_MAX:   cfg_reg.roi_x_max   <= cfg_wdata;
                REG_ROI_Y_MIN:   cfg_reg.roi_y_min   <= cfg_wdata[POS_W-1:0];
                REG_ROI_Y_MAX:   cfg_reg.roi_y_max   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    iirs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .accept      (accept),
        .pixel       (s_tdata[PIX_W-1:0]),
        .frame_start (s_tuser),
        .item        (item)
    );

    iirs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk  (aclk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (accept),
        .raddr (item.rx),
        .rdata (rdata)
    );

    iirs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .item     (item),
        .rdata    (rdata),
        .ready    (s_tready),
        .ram_wr   (ram_wr),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The last value of a region sits at its bottom right corner.
    assign done_col = POS_W'(last_col(cfg_reg) - DIM_W'(1) - {1'b0, cfg_reg.roi_x_min});
    assign done_row = POS_W'(last_row(cfg_reg) - DIM_W'(1) - {1'b0, cfg_reg.roi_y_min});

    `ASSERT_SAME(a_done_col, aclk, aresetn, m_tvalid && m_tlast, m_tdata[37:28] == done_col)
    `ASSERT_SAME(a_done_row, aclk, aresetn, m_tvalid && m_tlast, m_tdata[47:38] == done_row)
    `ASSERT_SAME(a_origin_sum, aclk, aresetn, m_tvalid && (m_tdata[47:28] == '0), m_tdata[27:0] <= SUM_W'(255))
    `ASSERT_NEXT(a_write_needs_output, aclk, aresetn, ram_wr.we, m_tvalid)

endmodule

// ===== rtl/iirs_ram.sv =====
module iirs_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/iirs_front.sv =====
module iirs_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  iirs_pkg::cfg_t             cfg,
    input  logic                       accept,
    input  logic [iirs_pkg::PIX_W-1:0] pixel,
    input  logic                       frame_start,
    output iirs_pkg::item_t            item
);
    import iirs_pkg::*;

    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [ROWS_W-1:0] rs_reg, rs_next;

    logic [POS_W-1:0]  col, row;
    logic [ROWS_W-1:0] rs_base, rs_sum;
    logic [DIM_W-1:0]  w, lc, lr;
    logic              in_x, in_y;

    always_comb begin
        col     = frame_start ? '0 : col_reg;
        row     = frame_start ? '0 : row_reg;
        rs_base = frame_start ? '0 : rs_reg;
        w       = eff_width(cfg.frame_width);
        lc      = last_col(cfg);
        lr      = last_row(cfg);

        in_x = ({1'b0, col} >= {1'b0, cfg.roi_x_min}) && ({1'b0, col} < cfg.roi_x_max);
        in_y = ({1'b0, row} >= {1'b0, cfg.roi_y_min}) && ({1'b0, row} < cfg.roi_y_max);

        item.res      = in_x && in_y;
        item.rx       = col - cfg.roi_x_min;
        item.ry       = row - cfg.roi_y_min;
        item.above_en = (item.ry != '0);
        rs_sum        = ((item.rx == '0) ? '0 : rs_base) + ROWS_W'(pixel);
        item.rs       = rs_sum;
        item.done     = ({1'b0, col} == lc - DIM_W'(1)) && ({1'b0, row} == lr - DIM_W'(1));

        col_next = col_reg;
        row_next = row_reg;
        rs_next  = rs_reg;
        if (accept) begin
            rs_next = item.res ? rs_sum : rs_base;
            if (({1'b0, col} + DIM_W'(1)) >= w) begin
                col_next = '0;
                if (({1'b0, row} + DIM_W'(1)) >= DIM_W'(MAX_HEIGHT)) begin
                    row_next = '0;
                end else begin
                    row_next = row + POS_W'(1);
                end
            end else begin
                col_next = col + POS_W'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            rs_reg  <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            rs_reg  <= rs_next;
        end
    end

endmodule

// ===== rtl/iirs_back.sv =====
module iirs_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  iirs_pkg::item_t                item,
    input  logic [iirs_pkg::SUM_W-1:0]     rdata,
    output logic                           ready,
    output iirs_pkg::ram_wr_t              ram_wr,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [iirs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import iirs_pkg::*;

    item_t            s1_reg;
    logic             s1_valid_reg, s1_valid_next;
    logic             fwd_reg;
    logic [SUM_W-1:0] fwd_val_reg;
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] out_sum_reg;
    logic [POS_W-1:0] out_col_reg, out_row_reg;
    logic             out_done_reg;

    logic             advance;
    logic [SUM_W-1:0] above, val;

    always_comb begin
        advance = s1_valid_reg && (!s1_reg.res || !out_valid_reg || m_tready);
        ready   = !s1_valid_reg || advance;

        if (!s1_reg.above_en) begin
            above = '0;
        end else if (fwd_reg) begin
            above = fwd_val_reg;
        end else begin
            above = rdata;
        end
        val = above + SUM_W'(s1_reg.rs);

        ram_wr.we   = advance && s1_reg.res;
        ram_wr.addr = s1_reg.rx;
        ram_wr.data = val;

        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance && s1_reg.res) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg      <= item;
            fwd_reg     <= ram_wr.we && (s1_reg.rx == item.rx);
            fwd_val_reg <= val;
        end
        if (advance && s1_reg.res) begin
            out_sum_reg  <= val;
            out_col_reg  <= s1_reg.rx;
            out_row_reg  <= s1_reg.ry;
            out_done_reg <= s1_reg.done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_row_reg, out_col_reg, out_sum_reg};
    assign m_tlast  = out_done_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import iirs_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0] area;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } sat_result_t;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_PIX,
        STEP_TYPED
    } step_kind_t;

    typedef struct packed {
        step_kind_t       kind;
        cfg_index_t       reg_idx;
        logic [DIM_W-1:0] reg_val;
        logic [PIX_W-1:0] pix;
        logic             fs;
        sat_result_t      want;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    cfg_index_t           cfg_addr = REG_FRAME_WIDTH;
    logic [DIM_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Predictor state: register copies, raster position, row sum and line buffer.
    logic [DIM_W-1:0]  p_width;
    logic [POS_W-1:0]  p_xmin;
    logic [DIM_W-1:0]  p_xmax;
    logic [POS_W-1:0]  p_ymin;
    logic [DIM_W-1:0]  p_ymax;
    int unsigned       p_col;
    int unsigned       p_row;
    logic [ROWS_W-1:0] p_rowsum;
    logic [SUM_W-1:0]  line_sums [MAX_WIDTH];

    sat_result_t expected_areas [$];
    int unsigned pixels_in = 0;
    int unsigned mismatches = 0;
    bit          typed_row = 1'b0;
    sat_result_t typed_val = '0;
    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;
    int unsigned sink_hold = 0;

    dir_row_t directed_rows [22] = '{
        '{STEP_TYPED, REG_FRAME_WIDTH, 11'd0, 8'd255, 1'b1, '{28'd255, 10'd0, 10'd0, 1'b0}},
        '{STEP_TYPED, REG_FRAME_WIDTH, 11'd0, 8'd0, 1'b0, '{28'd255, 10'd1, 10'd0, 1'b0}},
        '{STEP_TYPED, REG_FRAME_WIDTH, 11'd0, 8'd255, 1'b0, '{28'd510, 10'd2, 10'd0, 1'b0}},
        '{STEP_TYPED, REG_FRAME_WIDTH, 11'd0, 8'd7, 1'b1, '{28'd7, 10'd0, 10'd0, 1'b0}},
        '{STEP_CFG, REG_FRAME_WIDTH, 11'd0, 8'd0, 1'b0, '0},
        '{STEP_CFG, REG_ROI_X_MAX, 11'd1, 8'd0, 1'b0, '0},
        '{STEP_CFG, REG_ROI_Y_MAX, 11'd2, 8'd0, 1'b0, '0},
        '{STEP_TYPED, REG_FRAME_WIDTH, 11'd0, 8'd255, 1'b1, '{28'd255, 10'd0, 10'd0, 1'b0}},
        '{STEP_TYPED, REG_FRAME_WIDTH, 11'd0, 8'd255, 1'b0, '{28'd510, 10'd0, 10'd1, 1'b1}},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd9, 1'b0, '0},
        '{STEP_CFG, REG_ROI_X_MIN, 11'd5, 8'd0, 1'b0, '0},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd200, 1'b1, '0},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd100, 1'b0, '0},
        '{STEP_CFG, REG_FRAME_WIDTH, 11'd3, 8'd0, 1'b0, '0},
        '{STEP_CFG, REG_ROI_X_MIN, 11'd1, 8'd0, 1'b0, '0},
        '{STEP_CFG, REG_ROI_X_MAX, 11'd2047, 8'd0, 1'b0, '0},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd10, 1'b1, '0},
        '{STEP_TYPED, REG_FRAME_WIDTH, 11'd0, 8'd255, 1'b0, '{28'd255, 10'd0, 10'd0, 1'b0}},
        '{STEP_TYPED, REG_FRAME_WIDTH, 11'd0, 8'd255, 1'b0, '{28'd510, 10'd1, 10'd0, 1'b0}},
        '{STEP_PIX, REG_FRAME_WIDTH, 11'd0, 8'd1, 1'b0, '0},
        '{STEP_TYPED, REG_FRAME_WIDTH, 11'd0, 8'd255, 1'b0, '{28'd510, 10'd0, 10'd1, 1'b0}},
        '{STEP_TYPED, REG_FRAME_WIDTH, 11'd0, 8'd255, 1'b0, '{28'd1020, 10'd1, 10'd1, 1'b1}}
    };

    integral_image_roi_stream_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void predict_area(input logic [PIX_W-1:0] pix, input logic fs,
                                         output bit hit, output sat_result_t res);
        int unsigned      w;
        int unsigned      c;
        int unsigned      r;
        int unsigned      rx;
        int unsigned      ry;
        int unsigned      lc;
        int unsigned      lr;
        logic [SUM_W-1:0] above;
        hit = 1'b0;
        res = '0;
        w = (p_width == '0) ? 1 : ((p_width > MAX_WIDTH) ? MAX_WIDTH : p_width);
        if (fs) begin
            p_col = 0;
            p_row = 0;
            p_rowsum = '0;
        end
        c = p_col;
        r = p_row;
        if (c >= p_xmin && c < p_xmax && r >= p_ymin && r < p_ymax) begin
            rx = c - p_xmin;
            ry = r - p_ymin;
            if (rx == 0) begin
                p_rowsum = '0;
            end
            p_rowsum = p_rowsum + pix;
            above = (ry != 0) ? line_sums[rx] : '0;
            res.area = above + SUM_W'(p_rowsum);
            line_sums[rx] = res.area;
            lc = (p_xmax < w) ? p_xmax : w;
            lr = (p_ymax < MAX_HEIGHT) ? p_ymax : MAX_HEIGHT;
            res.col = POS_W'(rx);
            res.row = POS_W'(ry);
            res.last = (c == lc - 1) && (r == lr - 1);
            hit = 1'b1;
        end
        if (c + 1 >= w) begin
            p_col = 0;
            p_row = (r + 1 >= MAX_HEIGHT) ? 0 : r + 1;
        end else begin
            p_col = c + 1;
        end
    endfunction

    always @(posedge aclk) begin
        bit          hit;
        sat_result_t res;
        sat_result_t want;
        if (!aresetn) begin
            p_width = DIM_W'(MAX_WIDTH);
            p_xmin = '0;
            p_xmax = DIM_W'(MAX_WIDTH);
            p_ymin = '0;
            p_ymax = DIM_W'(MAX_HEIGHT);
            p_col = 0;
            p_row = 0;
            p_rowsum = '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_FRAME_WIDTH: p_width = cfg_wdata;
                    REG_ROI_X_MIN:   p_xmin = cfg_wdata[POS_W-1:0];
                    REG_ROI_X_MAX:   p_xmax = cfg_wdata;
                    REG_ROI_Y_MIN:   p_ymin = cfg_wdata[POS_W-1:0];
                    REG_ROI_Y_MAX:   p_ymax = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_area(s_tdata[PIX_W-1:0], s_tuser, hit, res);
                if (typed_row) begin
                    expected_areas.push_back(typed_val);
                end else if (hit) begin
                    expected_areas.push_back(res);
                end
                pixels_in++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_areas.size() == 0) begin
                    $error("unexpected result transaction: tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_areas.pop_front();
                    if (m_tdata[SUM_W-1:0] !== want.area) begin
                        $error("area_sum: expected %0d, got %0d", want.area,
                               m_tdata[SUM_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[SUM_W +: POS_W] !== want.col) begin
                        $error("roi_col: expected %0d, got %0d", want.col,
                               m_tdata[SUM_W +: POS_W]);
                        mismatches++;
                    end
                    if (m_tdata[SUM_W+POS_W +: POS_W] !== want.row) begin
                        $error("roi_row: expected %0d, got %0d", want.row,
                               m_tdata[SUM_W+POS_W +: POS_W]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("roi_done: expected %0d, got %0d", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else if (sink_idle && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            sink_hold = $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs, input bit typed,
                              input sat_result_t want);
        int unsigned seen;
        if (src_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        typed_row = typed;
        typed_val = want;
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= fs;
        seen = pixels_in;
        do @(negedge aclk); while (pixels_in == seen);
    endtask

    task automatic send_frame(input int unsigned n, input bit noise);
        for (int unsigned k = 0; k < n; k++) begin
            send_pixel(rand_pixel(), (k == 0) || (noise && $urandom_range(0, 49) == 0),
                       1'b0, '0);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_areas.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic program_reg(input cfg_index_t idx, input logic [DIM_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic program_roi(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] xmin,
                               input logic [DIM_W-1:0] xmax, input logic [DIM_W-1:0] ymin,
                               input logic [DIM_W-1:0] ymax);
        program_reg(REG_FRAME_WIDTH, w);
        program_reg(REG_ROI_X_MIN, xmin);
        program_reg(REG_ROI_X_MAX, xmax);
        program_reg(REG_ROI_Y_MIN, ymin);
        program_reg(REG_ROI_Y_MAX, ymax);
    endtask

    task automatic random_roi_phase();
        int unsigned      w;
        int unsigned      xmin;
        int unsigned      xmax;
        int unsigned      ymin;
        int unsigned      ymax;
        int unsigned      h;
        int unsigned      n;
        logic [DIM_W-1:0] wreg;
        w = $urandom_range(1, 12);
        wreg = (w == 1 && $urandom_range(0, 1) == 0) ? '0 : DIM_W'(w);
        xmin = $urandom_range(0, w - 1);
        xmax = ($urandom_range(0, 5) == 0) ? $urandom_range(0, xmin)
                                           : $urandom_range(xmin + 1, w + 2);
        ymin = $urandom_range(0, 3);
        ymax = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ymin)
                                           : $urandom_range(ymin + 1, ymin + 4);
        h = ymax + $urandom_range(0, 1);
        if (h == 0) begin
            h = 1;
        end
        program_roi(wreg, DIM_W'(xmin) | (DIM_W'($urandom_range(0, 1)) << POS_W),
                    DIM_W'(xmax), DIM_W'(ymin) | (DIM_W'($urandom_range(0, 1)) << POS_W),
                    DIM_W'(ymax));
        repeat ($urandom_range(1, 3)) begin
            n = w * h;
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, n);
            end
            send_frame(n, 1'b1);
        end
    endtask

    initial begin
        int unsigned phase;
        phase = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == STEP_CFG) begin
                settle();
                program_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                send_pixel(directed_rows[i].pix, directed_rows[i].fs,
                           directed_rows[i].kind == STEP_TYPED, directed_rows[i].want);
            end
        end
        settle();
        while (pixels_in < 360 || phase < 5) begin
            if (pixels_in > 300) begin
                src_idle = 1'b0;
                sink_idle = 1'b0;
            end else begin
                src_idle = $urandom_range(0, 3) != 0;
                sink_idle = $urandom_range(0, 3) != 0;
            end
            case (phase)
                2: begin
                    // A region one column wide puts transactions of one column back to back.
                    program_roi('0, '0, 11'd1, '0, 11'd2047);
                    send_frame(40, 1'b0);
                end
                4: begin
                    // A width above the maximum acts as the maximum.
                    program_roi(11'd2047, 11'd2, 11'd2047, '0, 11'd2);
                    send_frame(40, 1'b0);
                end
                default: random_roi_phase();
            endcase
            settle();
            phase++;
        end
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== integral_image_roi_stream_unit.f =====
+incdir+rtl
rtl/iirs_pkg.sv
rtl/iirs_ram.sv
rtl/iirs_front.sv
rtl/iirs_back.sv
rtl/integral_image_roi_stream_unit.sv
tb/tb.sv
